[src/tcld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled canvas line drawer package
// Request codes, coordinate type and the point record that the line stepper
// hands to the canvas control.
// ----------------------------------------------------------------------------
package tcld_pkg;

    localparam int COORD_W   = 11;
    localparam int INK_W     = 4;
    localparam int WORD_W    = 32;
    localparam int WADDR_W   = 13;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [INK_W-1:0] NIBBLE_MASK = 4'hF;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_point;

endpackage

[src/tcld_stepper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled canvas line stepper
// Holds the Bresenham walk state and moves to the next point of the line on
// each advance strobe.
// ----------------------------------------------------------------------------
module tcld_stepper
    import tcld_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_end_x,
    input  t_coord i_end_y,
    input  logic   i_advance,
    output t_point o_point
);

    t_coord              r_x, r_y, r_x1, r_y1;
    logic                r_sx, r_sy;
    logic signed [12:0]  r_dx, r_dy;
    logic signed [13:0]  r_err;

    logic signed [11:0]  diff_x, diff_y;
    logic        [11:0]  abs_x, abs_y;
    logic signed [12:0]  load_dx, load_dy;
    logic signed [14:0]  e2;
    logic                step_x, step_y;
    logic signed [13:0]  n_err;

    always_comb begin
        diff_x  = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        diff_y  = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        abs_x   = diff_x[11] ? 12'(-diff_x) : 12'(diff_x);
        abs_y   = diff_y[11] ? 12'(-diff_y) : 12'(diff_y);
        load_dx = $signed({1'b0, abs_x});
        load_dy = -$signed({1'b0, abs_y});

        e2      = {r_err, 1'b0};
        step_x  = e2 >= $signed({{2{r_dy[12]}}, r_dy});
        step_y  = e2 <= $signed({{2{r_dx[12]}}, r_dx});
        n_err   = r_err + (step_x ? {r_dy[12], r_dy} : 14'sd0)
                        + (step_y ? {r_dx[12], r_dx} : 14'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x   <= i_start_x;
            r_y   <= i_start_y;
            r_x1  <= i_end_x;
            r_y1  <= i_end_y;
            r_sx  <= diff_x > 12'sd0;
            r_sy  <= diff_y > 12'sd0;
            r_dx  <= load_dx;
            r_dy  <= load_dy;
            r_err <= {load_dx[12], load_dx} + {load_dy[12], load_dy};
        end else if (i_advance) begin
            r_err <= n_err;
            if (step_x) begin
                r_x <= r_sx ? r_x + 11'sd1 : r_x - 11'sd1;
            end
            if (step_y) begin
                r_y <= r_sy ? r_y + 11'sd1 : r_y - 11'sd1;
            end
        end
    end

    assign o_point.x    = r_x;
    assign o_point.y    = r_y;
    assign o_point.last = (r_x == r_x1) && (r_y == r_y1);

endmodule

[src/tiled_canvas_line_drawer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled canvas line drawer
// A 4-bit-per-pixel canvas of 8x8 tiles in one memory, with line drawing by
// read-modify-write, word readback and a full clear.
// Draw: each on-screen point is read and then written back, and off-screen
// points are skipped. Read: the word passes S_READ and S_DONE. Clear: one
// word per cycle. One request at a time; the canvas port sets the pace of
// every operation. Reset runs a clearing pass over all depth words (4800 by
// default) before the first request is taken.
// ----------------------------------------------------------------------------
module tiled_canvas_line_drawer
    import tcld_pkg::*;
#(
    parameter int TILE_COLUMNS = 30,
    parameter int TILE_ROWS    = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  t_coord             i_start_x,
    input  t_coord             i_start_y,
    input  t_coord             i_end_x,
    input  t_coord             i_end_y,
    input  logic [INK_W-1:0]   i_ink,
    input  logic [WADDR_W-1:0] i_word_address,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WORD_W-1:0]  o_read_data
);

    localparam int DEPTH = TILE_COLUMNS * TILE_ROWS * 8;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [10:0]   CANVAS_W  = 11'(TILE_COLUMNS * 8);
    localparam logic [10:0]   CANVAS_H  = 11'(TILE_ROWS * 8);
    localparam logic [15:0]   DEPTH_EXT = 16'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RD    = 6'b000100,
        S_WR    = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_cnt;
    logic                r_clr_item;
    logic [INK_W-1:0]    r_ink;
    logic [AW-1:0]       r_waddr;
    logic [2:0]          r_shift;
    logic                r_rd_ok;
    logic [WORD_W-1:0]   r_res;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_data;

    logic [WORD_W-1:0]   mem [DEPTH];
    logic [WORD_W-1:0]   r_mem_rdata;

    t_point              point;
    logic                accept, load, advance;
    logic                on_screen;
    logic [11:0]         tile_idx;
    logic [14:0]         pt_word;
    logic [AW-1:0]       pt_addr;
    logic [15:0]         in_addr_ext;
    logic                mem_re, mem_we;
    logic [AW-1:0]       mem_raddr, mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [WORD_W-1:0]   nib_mask, nib_ink;
    logic                out_load;

    tcld_stepper u_stepper (
        .i_clk     (i_clk),
        .i_load    (load),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .i_advance (advance),
        .o_point   (point)
    );

    always_comb begin
        accept      = i_valid && (r_state == S_IDLE);
        load        = accept && (i_operation == OP_DRAW);
        on_screen   = !point.x[10] && ({1'b0, point.x[9:0]} < CANVAS_W) &&
                      !point.y[10] && ({1'b0, point.y[9:0]} < CANVAS_H);
        tile_idx    = 12'(point.y[8:3]) * 12'(TILE_COLUMNS) + 12'(point.x[8:3]);
        pt_word     = {tile_idx, point.y[2:0]};
        pt_addr     = pt_word[AW-1:0];
        in_addr_ext = 16'(i_word_address);

        advance = ((r_state == S_RD) && !on_screen && !point.last) ||
                  ((r_state == S_WR) && !point.last);

        mem_re    = (accept && (i_operation == OP_READ)) ||
                    ((r_state == S_RD) && on_screen);
        mem_raddr = (r_state == S_IDLE) ? in_addr_ext[AW-1:0] : pt_addr;

        nib_mask  = WORD_W'(NIBBLE_MASK) << {r_shift, 2'b00};
        nib_ink   = WORD_W'(r_ink) << {r_shift, 2'b00};
        mem_we    = (r_state == S_WR) || (r_state == S_CLEAR);
        mem_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_waddr;
        mem_wdata = (r_state == S_CLEAR) ? '0 : ((r_mem_rdata & ~nib_mask) | nib_ink);

        out_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == LAST_ADDR) begin
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_DRAW:  n_state = S_RD;
                        OP_READ:  n_state = S_READ;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_RD: begin
                if (on_screen) begin
                    n_state = S_WR;
                end else if (point.last) begin
                    n_state = S_DONE;
                end
            end
            S_WR: begin
                n_state = point.last ? S_DONE : S_RD;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end else begin
                r_clr_cnt <= '0;
            end
            if (accept) begin
                r_clr_item <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ink   <= i_ink;
            r_rd_ok <= in_addr_ext < DEPTH_EXT;
            r_res   <= '0;
        end
        if (r_state == S_RD) begin
            r_waddr <= pt_addr;
            r_shift <= point.x[2:0];
        end
        if (r_state == S_READ) begin
            r_res <= r_rd_ok ? r_mem_rdata : '0;
        end
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_rdata <= mem[mem_raddr];
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while a previous one was still in progress");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD) && ($past(mem_raddr) == r_waddr))
        else $error("pixel write without a matching canvas read");

    a_clear_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (32'(r_clr_cnt) < 32'(DEPTH)))
        else $error("clearing pass ran past the canvas depth");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !i_ready |=> (r_state == S_DONE))
        else $error("result dropped while the output was stalled");

endmodule

[tb/tiled_canvas_line_drawer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled canvas line drawer checker
// Watches the request and result channels of the line drawer. It keeps its
// own copy of the tiled canvas, and it draws every accepted line into that
// copy with integer Bresenham steps. From this copy it works out the word
// that each request must return. Results are compared in order with the
// oldest expected word, and every mismatch is counted for the testbench top.
// ----------------------------------------------------------------------------
module tiled_canvas_line_drawer_checker
    import tcld_pkg::*;
#(
    parameter int TILE_COLUMNS = 30,
    parameter int TILE_ROWS    = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [1:0]         i_operation,
    input  t_coord             i_start_x,
    input  t_coord             i_start_y,
    input  t_coord             i_end_x,
    input  t_coord             i_end_y,
    input  logic [INK_W-1:0]   i_ink,
    input  logic [WADDR_W-1:0] i_word_address,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [WORD_W-1:0]  i_read_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int CANVAS_DEPTH  = TILE_COLUMNS * TILE_ROWS * 8;
    localparam int CANVAS_WIDTH  = TILE_COLUMNS * 8;
    localparam int CANVAS_HEIGHT = TILE_ROWS * 8;
    localparam int MAX_PRINTED   = 50;

    logic [WORD_W-1:0] canvas_q [CANVAS_DEPTH];
    logic [WORD_W-1:0] read_data_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_fail_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        o_fail_count++;
    endtask

    function automatic void plot_pixel(input int x, input int y, input logic [INK_W-1:0] ink);
        int word_idx;
        int shift;
        if (x < 0 || x >= CANVAS_WIDTH || y < 0 || y >= CANVAS_HEIGHT) begin
            return;
        end
        word_idx = ((y / 8) * TILE_COLUMNS + (x / 8)) * 8 + (y % 8);
        shift    = (x % 8) * INK_W;
        canvas_q[word_idx][shift +: INK_W] = ink;
    endfunction

    function automatic void trace_line(input int x0, input int y0, input int x1, input int y1,
                                       input logic [INK_W-1:0] ink);
        int dx;
        int dy;
        int step_x;
        int step_y;
        int err;
        int err2;
        dx     = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy     = (y1 > y0) ? y0 - y1 : y1 - y0;
        step_x = (x0 < x1) ? 1 : -1;
        step_y = (y0 < y1) ? 1 : -1;
        err    = dx + dy;
        forever begin
            plot_pixel(x0, y0, ink);
            if (x0 == x1 && y0 == y1) begin
                break;
            end
            err2 = 2 * err;
            if (err2 >= dy) begin
                err += dy;
                x0  += step_x;
            end
            if (err2 <= dx) begin
                err += dx;
                y0  += step_y;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        logic [WORD_W-1:0] expected_word;
        int sx;
        int sy;
        int ex;
        int ey;
        if (!i_rst_n) begin
            read_data_q.delete();
            foreach (canvas_q[i]) begin
                canvas_q[i] = '0;
            end
            o_pending = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (read_data_q.size() == 0) begin
                    report_mismatch($sformatf("result 0x%08h with no request outstanding",
                                              i_read_data));
                end else begin
                    expected_word = read_data_q.pop_front();
                    o_checked++;
                    if (i_read_data !== expected_word) begin
                        report_mismatch($sformatf("read_data 0x%08h, expected 0x%08h",
                                                  i_read_data, expected_word));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_word = '0;
                case (i_operation)
                    OP_DRAW: begin
                        sx = i_start_x;
                        sy = i_start_y;
                        ex = i_end_x;
                        ey = i_end_y;
                        trace_line(sx, sy, ex, ey, i_ink);
                    end
                    OP_READ: begin
                        if (i_word_address < CANVAS_DEPTH) begin
                            expected_word = canvas_q[i_word_address];
                        end
                    end
                    OP_CLEAR: begin
                        foreach (canvas_q[i]) begin
                            canvas_q[i] = '0;
                        end
                    end
                    default: begin
                    end
                endcase
                read_data_q.push_back(expected_word);
            end
            o_pending = read_data_q.size();
        end
    end

endmodule

[tb/tiled_canvas_line_drawer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled canvas line drawer testbench
// Sends line draws, canvas reads, clears and unused codes to the block. It
// starts with a short directed list of corner lines, reads, a clear and an
// unused code, and then runs three random phases with different idle rates
// on each channel. The block is also held back by a long result stall. A
// separate checker predicts every returned word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tiled_canvas_line_drawer_test;
    import tcld_pkg::*;

    localparam int TILE_COLUMNS    = 30;
    localparam int TILE_ROWS       = 20;
    localparam int CANVAS_DEPTH    = TILE_COLUMNS * TILE_ROWS * 8;
    localparam int CANVAS_WIDTH    = TILE_COLUMNS * 8;
    localparam int CANVAS_HEIGHT   = TILE_ROWS * 8;
    localparam int PHASE_ITEMS     = 200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 12_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_operation;
    t_coord             i_start_x;
    t_coord             i_start_y;
    t_coord             i_end_x;
    t_coord             i_end_y;
    logic [INK_W-1:0]   i_ink;
    logic [WADDR_W-1:0] i_word_address;
    logic               o_valid;
    logic               i_ready;
    logic [WORD_W-1:0]  o_read_data;

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_off_req;
    int cycle_count;
    int last_x;
    int last_y;
    int draws_sent;
    int reads_sent;
    int clears_sent;
    int unused_sent;

    tiled_canvas_line_drawer #(
        .TILE_COLUMNS(TILE_COLUMNS),
        .TILE_ROWS   (TILE_ROWS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_ink         (i_ink),
        .i_word_address(i_word_address),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data)
    );

    tiled_canvas_line_drawer_checker #(
        .TILE_COLUMNS(TILE_COLUMNS),
        .TILE_ROWS   (TILE_ROWS)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_operation   (i_operation),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_ink         (i_ink),
        .i_word_address(i_word_address),
        .i_rsp_valid   (o_valid),
        .i_rsp_ready   (i_ready),
        .i_read_data   (o_read_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("Regression FAIL");
        $finish;
    end

    // The long hold-off is counted here so the sender keeps offering requests meanwhile.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic int rand_coord();
        return int'($urandom_range(2047)) - 1024;
    endfunction

    function automatic int word_of(input int x, input int y);
        return ((y / 8) * TILE_COLUMNS + (x / 8)) * 8 + (y % 8);
    endfunction

    task automatic send_request(input logic [1:0] op, input int sx, input int sy, input int ex,
                                input int ey, input logic [INK_W-1:0] ink, input int addr);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_start_x      <= sx[COORD_W-1:0];
        i_start_y      <= sy[COORD_W-1:0];
        i_end_x        <= ex[COORD_W-1:0];
        i_end_y        <= ey[COORD_W-1:0];
        i_ink          <= ink;
        i_word_address <= addr[WADDR_W-1:0];
        do @(posedge i_clk); while (!o_ready);
        case (op)
            OP_DRAW:  draws_sent++;
            OP_READ:  reads_sent++;
            OP_CLEAR: clears_sent++;
            default:  unused_sent++;
        endcase
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic random_request(output logic [1:0] op_sent);
        int sel;
        int sx;
        int sy;
        int ex;
        int ey;
        int addr;
        logic [INK_W-1:0] ink;
        sel  = $urandom_range(99);
        sx   = rand_coord();
        sy   = rand_coord();
        ex   = rand_coord();
        ey   = rand_coord();
        ink  = INK_W'($urandom_range(15));
        addr = $urandom_range(8191);
        if (sel < 40) begin
            op_sent = OP_DRAW;
            sx = int'($urandom_range(279)) - 20;
            sy = int'($urandom_range(199)) - 20;
            if ($urandom_range(9) == 0) begin
                ex = sx;
                ey = sy;
            end else begin
                ex = sx + int'($urandom_range(80)) - 40;
                ey = sy + int'($urandom_range(80)) - 40;
            end
            last_x = sx;
            last_y = sy;
        end else if (sel < 45) begin
            op_sent = OP_DRAW;
        end else if (sel < 55) begin
            op_sent = OP_DRAW;
            sx = $urandom_range(CANVAS_WIDTH - 1);
            sy = $urandom_range(CANVAS_HEIGHT - 1);
            ex = $urandom_range(CANVAS_WIDTH - 1);
            ey = $urandom_range(CANVAS_HEIGHT - 1);
            last_x = ex;
            last_y = ey;
        end else if (sel < 91) begin
            op_sent = OP_READ;
            if ($urandom_range(3) != 0) begin
                sx = last_x + int'($urandom_range(8)) - 4;
                sy = last_y + int'($urandom_range(8)) - 4;
                sx = (sx < 0) ? 0 : (sx >= CANVAS_WIDTH) ? CANVAS_WIDTH - 1 : sx;
                sy = (sy < 0) ? 0 : (sy >= CANVAS_HEIGHT) ? CANVAS_HEIGHT - 1 : sy;
                addr = word_of(sx, sy);
            end
        end else if (sel < 94) begin
            op_sent = OP_CLEAR;
        end else begin
            op_sent = OP_UNUSED;
        end
        send_request(op_sent, sx, sy, ex, ey, ink, addr);
    endtask

    task automatic run_phase(input int n_items);
        int useful;
        logic [1:0] op_sent;
        useful = 0;
        while (useful < n_items) begin
            random_request(op_sent);
            if (op_sent != OP_UNUSED) begin
                useful++;
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_DRAW;
        i_start_x      = '0;
        i_start_y      = '0;
        i_end_x        = '0;
        i_end_y        = '0;
        i_ink          = '0;
        i_word_address = '0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        hold_off_req   = 1'b0;
        last_x         = 0;
        last_y         = 0;
        draws_sent     = 0;
        reads_sent     = 0;
        clears_sent    = 0;
        unused_sent    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner lines, single points, reads at and beyond the canvas end, and a clear.
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, 0);
        send_request(OP_DRAW, 0, 0, 0, 0, 4'hF, 0);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(0, 0));
        send_request(OP_DRAW, 239, 159, 239, 159, 4'hA, 0);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(239, 159));
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, CANVAS_DEPTH);
        send_request(OP_READ, -1, -1, -1, -1, 4'hF, 8191);
        send_request(OP_DRAW, -5, 3, 250, 3, 4'h5, 0);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(8, 3));
        send_request(OP_DRAW, 0, 3, 20, 3, 4'h0, 0);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(8, 3));
        send_request(OP_DRAW, 7, -3, 7, 170, 4'h9, 0);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(7, 100));
        send_request(OP_DRAW, -1024, -1024, 1023, 1023, 4'h3, 0);
        send_request(OP_DRAW, -1024, 1023, 1023, -1024, 4'hC, 0);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(100, 100));
        send_request(OP_DRAW, 300, 300, 500, 200, 4'h6, 0);
        send_request(OP_UNUSED, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     4'h7, $urandom_range(8191));
        send_request(OP_DRAW, 239, 0, 0, 159, 4'hE, 0);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(120, 80));
        send_request(OP_CLEAR, 5, 5, 9, 9, 4'hB, 17);
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(7, 100));
        send_request(OP_READ, 0, 0, 0, 0, 4'h0, word_of(239, 159));
        drain_results();

        tx_idle_pct = 34;
        rx_idle_pct = 51;
        run_phase(PHASE_ITEMS);
        drain_results();

        tx_idle_pct = 51;
        rx_idle_pct = 34;
        run_phase(PHASE_ITEMS);
        drain_results();

        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b1;
        run_phase(PHASE_ITEMS);
        drain_results();

        repeat (20) @(posedge i_clk);
        $display("Sent %0d draws, %0d reads, %0d clears and %0d unused codes.",
                 draws_sent, reads_sent, clears_sent, unused_sent);
        $display("Checked %0d results over %0d cycles with %0d mismatches.",
                 checked, cycle_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
